// ===== rtl/ssbdt_pkg.sv =====
// ----------------------------------------------------------------------------
// ssbdt_pkg
// Shared types and constants for the scaled sprite blitter with depth test.
// ----------------------------------------------------------------------------
package ssbdt_pkg;

   // field widths
   localparam int OP_W       = 2;
   localparam int INDEX_W    = 12;
   localparam int VALUE_W    = 24;
   localparam int POS_W      = 13;
   localparam int SIZE_W     = 12;
   localparam int DIST_W     = 24;
   localparam int LOCAL_W    = 12;
   localparam int PIX_X_W    = 10;
   localparam int PIX_Y_W    = 12;
   localparam int COLOR_W    = 24;

   localparam int SCR_W_W    = 11;
   localparam int SCR_H_W    = 12;
   localparam int TEX_DIM_W  = 7;

   // stream word widths
   localparam int REQ_DATA_W = 128;
   localparam int REQ_USER_W = OP_W;
   localparam int RSP_DATA_W = 48;
   localparam int RSP_USER_W = 1;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   // default sizes of the stores
   localparam int DEF_SCREEN_COLUMNS = 1024;
   localparam int DEF_TEXTURE_WORDS  = 4096;

   // register reset values
   localparam logic [SCR_W_W-1:0]   RST_SCREEN_WIDTH   = 11'd640;
   localparam logic [SCR_H_W-1:0]   RST_SCREEN_HEIGHT  = 12'd480;
   localparam logic [TEX_DIM_W-1:0] RST_TEXTURE_WIDTH  = 7'd64;
   localparam logic [TEX_DIM_W-1:0] RST_TEXTURE_HEIGHT = 7'd64;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TEXTURE_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TEXTURE_HEIGHT = 2'd3;

   // operations
   localparam logic [OP_W-1:0] OP_LOAD_DEPTH = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_TEXEL = 2'd1;
   localparam logic [OP_W-1:0] OP_DRAW       = 2'd2;

   // divider: quotient always below 128
   localparam int QUOT_W = TEX_DIM_W;
   localparam int PROD_W = LOCAL_W + TEX_DIM_W;
   localparam int ADDR_W = 2 * TEX_DIM_W + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DEPTH,
      ST_DIVIDE,
      ST_ADDR,
      ST_TEX_READ,
      ST_TEX_CHECK,
      ST_RESULT
   } state_type;

endpackage

// ===== rtl/ssbdt_ram.sv =====
// ----------------------------------------------------------------------------
// ssbdt_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ssbdt_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/scaled_sprite_blit_depth_test.sv =====
// ----------------------------------------------------------------------------
// scaled_sprite_blit_depth_test
// Sprite pixel engine: column depth buffer, texture store, clip, depth test
// and texel scaling by a shared bit-serial divider pair.
// ----------------------------------------------------------------------------
// channel | direction | tdata / data                      | tuser / index
// req_    | in        | load/draw fields, 128 bits         | op
// rsp_    | out       | pixel_x, pixel_y, pixel_color      | pixel_write
// csr_    | in        | register data, 12 bits             | register index
//
// A draw takes longer than a load; its time is set by the 7-step restoring
// divider (one quotient bit per cycle) and the registered reads of the depth
// and texture RAMs.
// One item is in flight; the result register lets the next item be accepted
// while a result waits on rsp_tready.
// Reset is synchronous; the RAMs are not cleared.
// ----------------------------------------------------------------------------
module scaled_sprite_blit_depth_test
   import ssbdt_pkg::*;
#(
   parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
   parameter int TEXTURE_WORDS  = DEF_TEXTURE_WORDS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // load_index, load_value, sprite_left, sprite_top, sprite_size,
   // sprite_distance, local_x, local_y, zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // op
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // pixel_x, pixel_y, pixel_color, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // pixel_write
   output logic [RSP_USER_W-1:0] rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int COL_AW = $clog2(SCREEN_COLUMNS);
   localparam int TEX_AW = $clog2(TEXTURE_WORDS);
   localparam logic [POS_W-1:0]  COLS_LIM = POS_W'(SCREEN_COLUMNS);
   localparam logic [ADDR_W-1:0] TEX_LIM  = ADDR_W'(TEXTURE_WORDS);
   localparam logic [2:0]        DIV_LAST = 3'(QUOT_W - 1);

   typedef struct packed {
      logic               quot_bit;
      logic [SIZE_W-1:0]  rem;
   } div_type;

   function automatic div_type div_step(input logic [SIZE_W-1:0] rem,
                                        input logic              nb,
                                        input logic [SIZE_W-1:0] dvs);
      logic [SIZE_W:0] trial;
      logic [SIZE_W:0] diff;
      div_type         res;
      trial = {rem, nb};
      diff  = trial - {1'b0, dvs};
      if (trial >= {1'b0, dvs}) begin
         res.quot_bit = 1'b1;
         res.rem      = diff[SIZE_W-1:0];
      end else begin
         res.quot_bit = 1'b0;
         res.rem      = trial[SIZE_W-1:0];
      end
      return res;
   endfunction

   // configuration
   logic [SCR_W_W-1:0]   screen_width_ff;
   logic [SCR_H_W-1:0]   screen_height_ff;
   logic [TEX_DIM_W-1:0] texture_width_ff;
   logic [TEX_DIM_W-1:0] texture_height_ff;

   // control
   state_type state_ff, state_in;
   logic [2:0] div_cnt_ff;
   logic       rsp_valid_ff;
   logic       hit_ff;

   // latched item
   logic [POS_W-1:0]   left_ff;
   logic [POS_W-1:0]   top_ff;
   logic [SIZE_W-1:0]  size_ff;
   logic [DIST_W-1:0]  dist_ff;
   logic [LOCAL_W-1:0] lx_ff;
   logic [LOCAL_W-1:0] ly_ff;

   // datapath
   logic [SIZE_W-1:0]  rem_x_ff, rem_y_ff;
   logic [QUOT_W-1:0]  low_x_ff, low_y_ff;
   logic [QUOT_W-1:0]  quot_x_ff, quot_y_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic [COLOR_W-1:0] color_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_write_ff;

   // control outputs
   logic accept;
   logic out_free;
   logic depth_rd_en;
   logic tex_rd_en;
   logic draw_ok;

   // request fields
   logic [OP_W-1:0]    req_op;
   logic [INDEX_W-1:0] req_index;
   logic [VALUE_W-1:0] req_value;
   logic [POS_W:0]     idx_col_ext;
   logic [ADDR_W-1:0]  idx_tex_ext;

   logic signed [POS_W:0] sx, sy;
   logic [PROD_W-1:0]     prod_x, prod_y;
   logic [ADDR_W-1:0]     addr_in;
   div_type               step_x, step_y;

   logic               depth_wr_en, tex_wr_en;
   logic [COLOR_W-1:0] depth_rd_data, tex_rd_data;

   assign req_op      = req_tuser;
   assign req_index   = req_tdata[11:0];
   assign req_value   = req_tdata[35:12];
   assign idx_col_ext = {2'b00, req_index};
   assign idx_tex_ext = {3'b000, req_index};

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign csr_ready = 1'b1;

   assign depth_wr_en = accept && (req_op == OP_LOAD_DEPTH) && (idx_col_ext < {1'b0, COLS_LIM});
   assign tex_wr_en   = accept && (req_op == OP_LOAD_TEXEL) && (idx_tex_ext < TEX_LIM);

   // screen position
   assign sx = $signed({left_ff[POS_W-1], left_ff}) + $signed({2'b00, lx_ff});
   assign sy = $signed({top_ff[POS_W-1], top_ff}) + $signed({2'b00, ly_ff});

   assign draw_ok = (size_ff != '0) && (lx_ff < size_ff) && (ly_ff < size_ff)
                 && !sx[POS_W] && (sx[POS_W-1:0] < {2'b00, screen_width_ff})
                 && (sx[POS_W-1:0] < COLS_LIM)
                 && !sy[POS_W] && (sy[POS_W-1:0] < {1'b0, screen_height_ff});

   assign prod_x  = PROD_W'(lx_ff) * PROD_W'(texture_width_ff);
   assign prod_y  = PROD_W'(ly_ff) * PROD_W'(texture_height_ff);
   assign step_x  = div_step(rem_x_ff, low_x_ff[QUOT_W-1], size_ff);
   assign step_y  = div_step(rem_y_ff, low_y_ff[QUOT_W-1], size_ff);
   assign addr_in = ADDR_W'(quot_y_ff) * ADDR_W'(texture_width_ff) + ADDR_W'(quot_x_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_op == OP_DRAW) ? ST_CHECK : ST_RESULT;
            end
         end
         ST_CHECK:     state_in = draw_ok ? ST_DEPTH : ST_RESULT;
         ST_DEPTH:     state_in = (depth_rd_data > dist_ff) ? ST_DIVIDE : ST_RESULT;
         ST_DIVIDE: begin
            if (div_cnt_ff == DIV_LAST) begin
               state_in = ST_ADDR;
            end
         end
         ST_ADDR:      state_in = ST_TEX_READ;
         ST_TEX_READ:  state_in = (addr_ff < TEX_LIM) ? ST_TEX_CHECK : ST_RESULT;
         ST_TEX_CHECK: state_in = ST_RESULT;
         ST_RESULT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_tready  = 1'b0;
      depth_rd_en = 1'b0;
      tex_rd_en   = 1'b0;
      unique case (state_ff)
         ST_IDLE:     req_tready  = 1'b1;
         ST_CHECK:    depth_rd_en = draw_ok;
         ST_TEX_READ: tex_rd_en   = addr_ff < TEX_LIM;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         div_cnt_ff        <= '0;
         rsp_valid_ff      <= 1'b0;
         hit_ff            <= 1'b0;
         screen_width_ff   <= RST_SCREEN_WIDTH;
         screen_height_ff  <= RST_SCREEN_HEIGHT;
         texture_width_ff  <= RST_TEXTURE_WIDTH;
         texture_height_ff <= RST_TEXTURE_HEIGHT;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_SCREEN_WIDTH:   screen_width_ff   <= csr_data[SCR_W_W-1:0];
               CSR_SCREEN_HEIGHT:  screen_height_ff  <= csr_data[SCR_H_W-1:0];
               CSR_TEXTURE_WIDTH:  texture_width_ff  <= csr_data[TEX_DIM_W-1:0];
               CSR_TEXTURE_HEIGHT: texture_height_ff <= csr_data[TEX_DIM_W-1:0];
               default: begin
               end
            endcase
         end
         if (state_ff == ST_CHECK) begin
            div_cnt_ff <= '0;
         end else if (state_ff == ST_DIVIDE) begin
            div_cnt_ff <= div_cnt_ff + 3'd1;
         end
         if (accept) begin
            hit_ff <= 1'b0;
         end else if (state_ff == ST_TEX_CHECK) begin
            hit_ff <= tex_rd_data != '0;
         end
         if (state_ff == ST_RESULT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         left_ff <= req_tdata[48:36];
         top_ff  <= req_tdata[61:49];
         size_ff <= req_tdata[73:62];
         dist_ff <= req_tdata[97:74];
         lx_ff   <= req_tdata[109:98];
         ly_ff   <= req_tdata[121:110];
      end
      if (state_ff == ST_CHECK) begin
         rem_x_ff  <= prod_x[PROD_W-1:QUOT_W];
         low_x_ff  <= prod_x[QUOT_W-1:0];
         rem_y_ff  <= prod_y[PROD_W-1:QUOT_W];
         low_y_ff  <= prod_y[QUOT_W-1:0];
         quot_x_ff <= '0;
         quot_y_ff <= '0;
      end else if (state_ff == ST_DIVIDE) begin
         rem_x_ff  <= step_x.rem;
         low_x_ff  <= {low_x_ff[QUOT_W-2:0], 1'b0};
         quot_x_ff <= {quot_x_ff[QUOT_W-2:0], step_x.quot_bit};
         rem_y_ff  <= step_y.rem;
         low_y_ff  <= {low_y_ff[QUOT_W-2:0], 1'b0};
         quot_y_ff <= {quot_y_ff[QUOT_W-2:0], step_y.quot_bit};
      end
      if (state_ff == ST_ADDR) begin
         addr_ff <= addr_in;
      end
      if (state_ff == ST_TEX_CHECK) begin
         color_ff <= tex_rd_data;
      end
      if (state_ff == ST_RESULT && out_free) begin
         rsp_write_ff <= hit_ff;
         if (hit_ff) begin
            rsp_data_ff <= {2'b00, color_ff, sy[PIX_Y_W-1:0], sx[PIX_X_W-1:0]};
         end else begin
            rsp_data_ff <= '0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_write_ff;

   ssbdt_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (SCREEN_COLUMNS)
   ) u_depth_ram (
      .clock   (clock),
      .wr_en   (depth_wr_en),
      .wr_addr (idx_col_ext[COL_AW-1:0]),
      .wr_data (req_value),
      .rd_en   (depth_rd_en),
      .rd_addr (sx[COL_AW-1:0]),
      .rd_data (depth_rd_data)
   );

   ssbdt_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (TEXTURE_WORDS)
   ) u_tex_ram (
      .clock   (clock),
      .wr_en   (tex_wr_en),
      .wr_addr (idx_tex_ext[TEX_AW-1:0]),
      .wr_data (req_value),
      .rd_en   (tex_rd_en),
      .rd_addr (addr_ff[TEX_AW-1:0]),
      .rd_data (tex_rd_data)
   );

endmodule

// ===== rtl/ssbdt_checker.sv =====
// ----------------------------------------------------------------------------
// ssbdt_checker
// Port-level checks for the sprite blitter, bound to the top level.
// ----------------------------------------------------------------------------
module ssbdt_checker
   import ssbdt_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser
);

   // a word held back keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp word changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_tvalid)
      else $error("rsp valid right after reset");

   // one item in flight
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item accepted while busy");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("fields not zero on a non-write");

   a_hit_opaque: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[45:22] != '0)
      else $error("transparent texel written");

endmodule

bind scaled_sprite_blit_depth_test ssbdt_checker u_ssbdt_checker (.*);

// ===== tb/tb_scaled_sprite_blit_depth_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_scaled_sprite_blit_depth_test
// Self-checking bench for the sprite pixel engine. A queue of depth, texel,
// draw and unused-op words feeds the request stream; a built-in predictor
// shades each accepted word and the response stream is checked field by
// field. Runs through several screen and texture settings, with and without
// random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_scaled_sprite_blit_depth_test;
   import ssbdt_pkg::*;

   localparam int SCREEN_COLS = DEF_SCREEN_COLUMNS;
   localparam int TEX_WORDS   = DEF_TEXTURE_WORDS;
   localparam int N_PHASES    = 8;
   localparam int STALL_LIMIT = 2000;
   localparam int TAIL_CYCLES = 40;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]           op;
      logic [INDEX_W-1:0]        load_index;
      logic [VALUE_W-1:0]        load_value;
      logic signed [POS_W-1:0]   sprite_left;
      logic signed [POS_W-1:0]   sprite_top;
      logic [SIZE_W-1:0]         sprite_size;
      logic [DIST_W-1:0]         sprite_distance;
      logic [LOCAL_W-1:0]        local_x;
      logic [LOCAL_W-1:0]        local_y;
   } blit_word_type;

   typedef struct packed {
      logic                 pixel_write;
      logic [PIX_X_W-1:0]   pixel_x;
      logic [PIX_Y_W-1:0]   pixel_y;
      logic [COLOR_W-1:0]   pixel_color;
   } pixel_result_type;

   typedef struct packed {
      bit hit;
      int sx;
      int sy;
      int addr;
   } pixel_target_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_SCREEN_WIDTH;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   scaled_sprite_blit_depth_test u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // predictor state
   logic [SCR_W_W-1:0]   scr_w = RST_SCREEN_WIDTH;
   logic [SCR_H_W-1:0]   scr_h = RST_SCREEN_HEIGHT;
   logic [TEX_DIM_W-1:0] tex_w = RST_TEXTURE_WIDTH;
   logic [TEX_DIM_W-1:0] tex_h = RST_TEXTURE_HEIGHT;
   logic [COLOR_W-1:0]   depth_mem [SCREEN_COLS];
   logic [COLOR_W-1:0]   texel_mem [TEX_WORDS];

   // generator bookkeeping: which store entries a draw may safely read
   bit depth_set [SCREEN_COLS];
   bit texel_set [TEX_WORDS];

   blit_word_type    pending_words [$];
   pixel_result_type expected_pixels [$];
   blit_word_type    req_item = '0;
   logic             req_hs = 1'b0;

   int words_queued   = 0;
   int useful_words   = 0;
   int words_accepted = 0;
   int draws_accepted = 0;
   int writes_seen    = 0;
   int mismatches     = 0;
   int stall_cycles   = 0;
   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;

   // screen position and texel address a draw resolves to, if it survives
   // the sprite bounds and the clip
   function automatic pixel_target_type locate_pixel(blit_word_type w);
      pixel_target_type t;
      int col;
      int row;
      t = '0;
      if (w.op != OP_DRAW || w.sprite_size == 0 || w.local_x >= w.sprite_size ||
          w.local_y >= w.sprite_size)
         return t;
      t.sx = int'($signed(w.sprite_left)) + int'(w.local_x);
      t.sy = int'($signed(w.sprite_top)) + int'(w.local_y);
      if (t.sx < 0 || t.sx >= int'(scr_w) || t.sx >= SCREEN_COLS)
         return t;
      if (t.sy < 0 || t.sy >= int'(scr_h))
         return t;
      col = int'(w.local_x) * int'(tex_w) / int'(w.sprite_size);
      row = int'(w.local_y) * int'(tex_h) / int'(w.sprite_size);
      t.addr = row * int'(tex_w) + col;
      t.hit = 1'b1;
      return t;
   endfunction

   function automatic pixel_result_type shade_pixel(blit_word_type w);
      pixel_target_type t;
      pixel_result_type r;
      r = '0;
      case (w.op)
         OP_LOAD_DEPTH: begin
            if (int'(w.load_index) < SCREEN_COLS)
               depth_mem[w.load_index] = w.load_value;
         end
         OP_LOAD_TEXEL: begin
            if (int'(w.load_index) < TEX_WORDS)
               texel_mem[w.load_index] = w.load_value;
         end
         OP_DRAW: begin
            t = locate_pixel(w);
            if (t.hit && depth_mem[t.sx] > w.sprite_distance && t.addr < TEX_WORDS &&
                texel_mem[t.addr] != 0) begin
               r.pixel_write = 1'b1;
               r.pixel_x = PIX_X_W'(t.sx);
               r.pixel_y = PIX_Y_W'(t.sy);
               r.pixel_color = texel_mem[t.addr];
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic void check_field(string name, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   // request driver and response stall
   always @(negedge clock) begin
      blit_word_type next_word;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_hs) begin
         if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_word = pending_words.pop_front();
            req_item <= next_word;
            req_tuser <= next_word.op;
            req_tdata <= {6'd0, next_word.local_y, next_word.local_x,
                          next_word.sprite_distance, next_word.sprite_size,
                          next_word.sprite_top, next_word.sprite_left,
                          next_word.load_value, next_word.load_index};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= reset ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
   end

   // monitor, predictor and watchdog
   always @(posedge clock) begin
      pixel_result_type want;
      if (reset) begin
         req_hs <= 1'b0;
         stall_cycles = 0;
      end else begin
         req_hs <= req_tvalid && req_tready;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SCREEN_WIDTH:   scr_w = csr_data[SCR_W_W-1:0];
               CSR_SCREEN_HEIGHT:  scr_h = csr_data[SCR_H_W-1:0];
               CSR_TEXTURE_WIDTH:  tex_w = csr_data[TEX_DIM_W-1:0];
               CSR_TEXTURE_HEIGHT: tex_h = csr_data[TEX_DIM_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pixels.size() == 0) begin
               $error("pixel result word with no request outstanding");
               mismatches++;
            end else begin
               want = expected_pixels.pop_front();
               if (want.pixel_write)
                  writes_seen++;
               check_field("pixel_write", want.pixel_write, rsp_tuser[0]);
               check_field("pixel_x", want.pixel_x, rsp_tdata[9:0]);
               check_field("pixel_y", want.pixel_y, rsp_tdata[21:10]);
               check_field("pixel_color", want.pixel_color, rsp_tdata[45:22]);
            end
         end
         if (req_tvalid && req_tready) begin
            expected_pixels.push_back(shade_pixel(req_item));
            words_accepted++;
            if (req_item.op == OP_DRAW)
               draws_accepted++;
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("scaled_sprite_blit_depth_test: mismatch");
            $finish;
         end
      end
   end

   // ---------------- stimulus ----------------

   function automatic logic [COLOR_W-1:0] random_texel();
      return ($urandom_range(3) == 0) ? '0 : COLOR_W'($urandom);
   endfunction

   function automatic blit_word_type noise_word(logic [OP_W-1:0] op);
      blit_word_type w;
      w.op = op;
      w.load_index = INDEX_W'($urandom);
      w.load_value = VALUE_W'($urandom);
      w.sprite_left = POS_W'($urandom);
      w.sprite_top = POS_W'($urandom);
      w.sprite_size = SIZE_W'($urandom);
      w.sprite_distance = DIST_W'($urandom);
      w.local_x = LOCAL_W'($urandom);
      w.local_y = LOCAL_W'($urandom);
      return w;
   endfunction

   function automatic blit_word_type load_word(logic [OP_W-1:0] op, int index, int value);
      blit_word_type w;
      w = '0;
      w.op = op;
      w.load_index = INDEX_W'(index);
      w.load_value = VALUE_W'(value);
      return w;
   endfunction

   function automatic blit_word_type draw_word(int left, int top, int size, int distance,
                                               int lx, int ly);
      blit_word_type w;
      w = '0;
      w.op = OP_DRAW;
      w.sprite_left = POS_W'(left);
      w.sprite_top = POS_W'(top);
      w.sprite_size = SIZE_W'(size);
      w.sprite_distance = DIST_W'(distance);
      w.local_x = LOCAL_W'(lx);
      w.local_y = LOCAL_W'(ly);
      return w;
   endfunction

   task automatic queue_word(blit_word_type w);
      pending_words.push_back(w);
      words_queued++;
      case (w.op)
         OP_LOAD_DEPTH: begin
            if (int'(w.load_index) < SCREEN_COLS) begin
               depth_set[w.load_index] = 1'b1;
               useful_words++;
            end
         end
         OP_LOAD_TEXEL: begin
            texel_set[w.load_index] = 1'b1;
            useful_words++;
         end
         OP_DRAW: useful_words++;
         default: ;
      endcase
   endtask

   // a draw never reads a store entry that was not loaded first
   task automatic queue_draw(blit_word_type w);
      pixel_target_type t;
      t = locate_pixel(w);
      if (t.hit) begin
         if (!depth_set[t.sx])
            queue_word(load_word(OP_LOAD_DEPTH, t.sx, int'($urandom_range(24'hFFFFFF))));
         if (t.addr < TEX_WORDS && !texel_set[t.addr])
            queue_word(load_word(OP_LOAD_TEXEL, t.addr, int'(random_texel())));
      end
      queue_word(w);
   endtask

   task automatic random_draw();
      blit_word_type w;
      int size;
      int lx;
      int ly;
      int span;
      int sx_t;
      int sy_t;
      w = noise_word(OP_DRAW);
      if ($urandom_range(99) < 80) begin
         size = ($urandom_range(99) < 85) ? int'($urandom_range(64, 1))
                                          : int'($urandom_range(4095, 1));
         lx = int'($urandom_range(size - 1, 0));
         ly = int'($urandom_range(size - 1, 0));
         span = (int'(scr_w) > SCREEN_COLS) ? SCREEN_COLS : int'(scr_w);
         sx_t = int'($urandom_range(span + 3, 0)) - 2;
         sy_t = int'($urandom_range(int'(scr_h) + 3, 0)) - 2;
         w.sprite_size = SIZE_W'(size);
         w.local_x = LOCAL_W'(lx);
         w.local_y = LOCAL_W'(ly);
         w.sprite_left = POS_W'(sx_t - lx);
         w.sprite_top = POS_W'(sy_t - ly);
         case ($urandom_range(9))
            0: w.sprite_distance = '0;
            1: w.sprite_distance = '1;
            default: ;
         endcase
      end
      queue_draw(w);
   endtask

   task automatic random_item();
      blit_word_type w;
      int pick;
      int used;
      pick = int'($urandom_range(99));
      if (pick < 55) begin
         random_draw();
      end else if (pick < 75) begin
         w = noise_word(OP_LOAD_DEPTH);
         if ($urandom_range(9) != 0)
            w.load_index = INDEX_W'($urandom_range(SCREEN_COLS - 1, 0));
         queue_word(w);
      end else if (pick < 95) begin
         w = noise_word(OP_LOAD_TEXEL);
         w.load_value = random_texel();
         used = int'(tex_w) * int'(tex_h);
         if (used > 0 && $urandom_range(99) < 70)
            w.load_index = INDEX_W'($urandom_range(used - 1, 0));
         queue_word(w);
      end else begin
         queue_word(noise_word(OP_UNUSED));
      end
   endtask

   task automatic directed_words();
      queue_word(load_word(OP_LOAD_DEPTH, 0, 24'hFFFFFF));
      queue_word(load_word(OP_LOAD_DEPTH, 639, 24'h000100));
      queue_word(load_word(OP_LOAD_DEPTH, SCREEN_COLS - 1, 24'h123456));
      queue_word(load_word(OP_LOAD_DEPTH, 4095, 24'hABCDEF));   // beyond the buffer
      queue_word(load_word(OP_LOAD_TEXEL, 0, 24'hFFFFFF));
      queue_word(load_word(OP_LOAD_TEXEL, 4095, 24'h000001));
      queue_word(load_word(OP_LOAD_TEXEL, 65, 24'h000000));     // transparent
      queue_word(noise_word(OP_UNUSED));
      queue_draw(draw_word(0, 0, 1, 0, 0, 0));
      queue_draw(draw_word(576, 416, 64, 24'h0000FF, 63, 63));  // last column and row
      queue_draw(draw_word(576, 416, 64, 24'h000100, 63, 63));  // depth equal: hidden
      queue_draw(draw_word(-1, -1, 64, 0, 1, 1));               // transparent texel
      queue_draw(draw_word(0, 0, 0, 0, 0, 0));                  // empty sprite
      queue_draw(draw_word(0, 0, 10, 0, 10, 0));
      queue_draw(draw_word(0, 0, 10, 0, 0, 10));
      queue_draw(draw_word(0, 0, 4095, 0, 4095, 4095));
      queue_draw(draw_word(-4096, -4096, 1, 0, 0, 0));
      queue_draw(draw_word(640, 0, 1, 0, 0, 0));                // right clip
      queue_draw(draw_word(0, -1, 1, 0, 0, 0));
      queue_draw(draw_word(0, 480, 1, 0, 0, 0));                // bottom clip
      queue_draw(draw_word(4095, 4095, 1, 0, 0, 0));
      queue_draw(draw_word(-3994, -3994, 4095, 24'h000010, 4094, 4094));
      queue_draw(draw_word(0, 0, 1, 24'hFFFFFF, 0, 0));
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] index, int value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (words_accepted != words_queued || expected_pixels.size() != 0);
   endtask

   initial begin
      int phase_words [N_PHASES];
      int setting [4];
      int target;
      phase_words = '{220, 220, 200, 220, 40, 40, 380, 380};
      target = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int p = 0; p < N_PHASES; p++) begin
         if (p > 0) begin
            wait_idle();
            case (p)
               1: setting = '{1024, 4095, 64, 64};
               2: setting = '{1, 1, 1, 1};
               4: setting = '{1024, 4095, 0, 0};
               5: setting = '{0, 0, 64, 64};
               default: setting = '{int'($urandom_range(1024, 1)),
                                    int'($urandom_range(4095, 1)),
                                    int'($urandom_range(64, 1)),
                                    int'($urandom_range(64, 1))};
            endcase
            csr_write(CSR_SCREEN_WIDTH, setting[0]);
            csr_write(CSR_SCREEN_HEIGHT, setting[1]);
            csr_write(CSR_TEXTURE_WIDTH, setting[2]);
            csr_write(CSR_TEXTURE_HEIGHT, setting[3]);
            @(negedge clock);
            csr_valid <= 1'b0;
         end
         if (p < 3) begin
            send_idle_pct = 11;
            recv_idle_pct = 65;
         end else if (p < 6) begin
            send_idle_pct = 65;
            recv_idle_pct = 11;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (p == 0)
            directed_words();
         target += phase_words[p];
         while (useful_words < target)
            random_item();
      end

      wait_idle();
      repeat (TAIL_CYCLES) @(negedge clock);
      $display("covered %0d request words (%0d draws, %0d pixel writes)",
               words_accepted, draws_accepted, writes_seen);
      $display("over %0d screen/texture settings, with and without stream stalls",
               N_PHASES);
      if (mismatches == 0) begin
         $display("scaled_sprite_blit_depth_test: match");
      end else begin
         $display("scaled_sprite_blit_depth_test: mismatch");
      end
      $finish;
   end

endmodule
